// File: rtl/csu_pkg.sv
// Shared types and default constants for the counting semaphore unit.
package csu_pkg;

    localparam int NumSemDefault     = 16;
    localparam int QueueDepthDefault = 16;
    localparam int MaxPassesDefault  = 255;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_WAIT  = 2'd1,
        CMD_POST  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_DONE       = 3'd0,
        ST_BLOCKED    = 3'd1,
        ST_WOKEN      = 3'd2,
        ST_NONE_FREE  = 3'd3,
        ST_SATURATED  = 3'd4,
        ST_QUEUE_FULL = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_EVAL,
        S_WAKE
    } state_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [3:0] sem_id;
        logic [3:0] caller_pid;
        logic [7:0] initial_passes;
    } item_t;

    typedef struct packed {
        status_t    status;
        logic [3:0] result_sem;
        logic [3:0] woken_pid;
    } result_t;

endpackage

// File: rtl/csu_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module csu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/counting_semaphore_unit_core.sv
// Top level of the counting semaphore unit: command sequencer, record table and wait queues.
//
// A command beat is taken at a rising edge where start is high and busy is low, and
// exactly one result beat follows on result, marked by a one-cycle done pulse; the
// receiver cannot hold it off, so it must take the result in that cycle. Each command
// runs as a short sequence over one record memory (one entry per semaphore: owner,
// pass count, queue head and fill) and one wait-queue memory, both with registered
// reads, so the read-modify-write of a record sets the latency. Wait and post run
// through a read state and an evaluate state to the done pulse, and a post that wakes
// a waiter adds a wake state because the waiter's pid comes from a second memory read.
// An allocate scans the records from semaphore 0 upward, with a read state and an
// evaluate state for each record visited, up to NUM_SEMAPHORES records.
// A wait or post on an id at or above NUM_SEMAPHORES, or an unknown command, is
// answered with status done in the cycle after acceptance and changes nothing. Records
// carry one valid bit each, cleared by reset, so an unwritten record reads as a free
// semaphore with zero count and an empty queue; no clearing pass is needed.
module counting_semaphore_unit_core #(
    parameter int NUM_SEMAPHORES = csu_pkg::NumSemDefault,
    parameter int QUEUE_DEPTH    = csu_pkg::QueueDepthDefault,
    parameter int MAX_PASSES     = csu_pkg::MaxPassesDefault
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  csu_pkg::item_t   item,
    output logic             busy,
    output logic             done,
    output csu_pkg::result_t result
);

    import csu_pkg::*;

    localparam int SW   = $clog2(NUM_SEMAPHORES);
    localparam int HW   = $clog2(QUEUE_DEPTH);
    localparam int FW   = $clog2(QUEUE_DEPTH + 1);
    localparam int PW   = $clog2(MAX_PASSES + 1);
    localparam int WAW  = $clog2(NUM_SEMAPHORES * QUEUE_DEPTH);
    localparam int SUMW = HW + 1;

    typedef struct packed {
        logic [3:0]    owner;
        logic [PW-1:0] passes;
        logic [HW-1:0] head;
        logic [FW-1:0] fill;
    } rec_t;

    localparam int RecW = $bits(rec_t);

    // Sequencer and captured command.
    state_t                    state_reg, state_next;
    item_t                     item_reg, item_next;
    logic [SW-1:0]             idx_reg, idx_next;
    logic [NUM_SEMAPHORES-1:0] rec_valid_reg, rec_valid_next;
    logic                      done_reg, done_next;
    result_t                   result_reg, result_next;

    // Memory ports.
    logic            rec_we;
    rec_t            rec_wdata;
    logic [RecW-1:0] rec_rdata;
    logic            wq_we;
    logic [WAW-1:0]  wq_waddr;
    logic [WAW-1:0]  wq_raddr;
    logic [3:0]      wq_rdata;

    // Decoded record and derived conditions.
    rec_t            rec_cur;
    logic            sem_ok;
    logic            go_rd;
    logic            last_idx;
    logic            queue_full;
    logic            pass_at_max;
    logic            init_over;
    logic [SUMW-1:0] slot_sum;
    logic [HW-1:0]   slot;
    logic [HW-1:0]   head_inc;
    logic [WAW-1:0]  wq_base;

    csu_ram #(
        .WIDTH (RecW),
        .DEPTH (NUM_SEMAPHORES)
    ) u_rec_ram (
        .clk   (clk),
        .we    (rec_we),
        .waddr (idx_reg),
        .wdata (rec_wdata),
        .raddr (idx_reg),
        .rdata (rec_rdata)
    );

    csu_ram #(
        .WIDTH (4),
        .DEPTH (NUM_SEMAPHORES * QUEUE_DEPTH)
    ) u_wait_ram (
        .clk   (clk),
        .we    (wq_we),
        .waddr (wq_waddr),
        .wdata (item_reg.caller_pid),
        .raddr (wq_raddr),
        .rdata (wq_rdata)
    );

    // A record never written reads as a free semaphore with an empty queue.
    assign rec_cur = rec_valid_reg[idx_reg] ? rec_t'(rec_rdata) : '0;

    assign sem_ok = 32'(item.sem_id) < NUM_SEMAPHORES;
    assign go_rd  = (item.cmd == CMD_ALLOC) ||
                    (((item.cmd == CMD_WAIT) || (item.cmd == CMD_POST)) && sem_ok);

    assign last_idx    = idx_reg == SW'(NUM_SEMAPHORES - 1);
    assign queue_full  = 32'(rec_cur.fill) >= QUEUE_DEPTH;
    assign pass_at_max = 32'(rec_cur.passes) >= MAX_PASSES;
    assign init_over   = 32'(item_reg.initial_passes) > MAX_PASSES;

    // Tail slot: head plus fill stays below twice the depth, so one subtract wraps it.
    assign slot_sum = SUMW'(rec_cur.head) + SUMW'(rec_cur.fill);
    assign slot     = (slot_sum >= SUMW'(QUEUE_DEPTH)) ?
                      HW'(slot_sum - SUMW'(QUEUE_DEPTH)) : HW'(slot_sum);
    assign head_inc = (rec_cur.head == HW'(QUEUE_DEPTH - 1)) ?
                      '0 : rec_cur.head + HW'(1);

    assign wq_base  = WAW'(idx_reg) * WAW'(QUEUE_DEPTH);
    assign wq_waddr = wq_base + WAW'(slot);
    assign wq_raddr = wq_base + WAW'(rec_cur.head);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && go_rd)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_IDLE;
                case (item_reg.cmd)
                    CMD_ALLOC:
                    begin
                        if ((rec_cur.owner != 4'd0) && !last_idx)
                        begin
                            state_next = S_RD;
                        end
                    end
                    CMD_POST:
                    begin
                        if (rec_cur.fill != '0)
                        begin
                            state_next = S_WAKE;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_WAKE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath, memory writes and result.
    always_comb
    begin
        item_next      = item_reg;
        idx_next       = idx_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        rec_we         = 1'b0;
        rec_wdata      = rec_cur;
        wq_we          = 1'b0;
        rec_valid_next = rec_valid_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next = item;
                    idx_next  = (item.cmd == CMD_ALLOC) ? '0 : SW'(item.sem_id);
                    if (!go_rd)
                    begin
                        done_next   = 1'b1;
                        result_next = '{status: ST_DONE, result_sem: 4'd0, woken_pid: 4'd0};
                    end
                end
            end
            S_RD:
            begin
                done_next = 1'b0;
            end
            S_EVAL:
            begin
                result_next = '{status: ST_DONE, result_sem: 4'd0, woken_pid: 4'd0};
                case (item_reg.cmd)
                    CMD_ALLOC:
                    begin
                        if (rec_cur.owner == 4'd0)
                        begin
                            rec_we           = 1'b1;
                            rec_wdata.owner  = item_reg.caller_pid;
                            rec_wdata.passes = init_over ? PW'(MAX_PASSES) :
                                                           PW'(item_reg.initial_passes);
                            rec_wdata.head   = '0;
                            rec_wdata.fill   = '0;
                            done_next        = 1'b1;
                            result_next.status     = init_over ? ST_SATURATED : ST_DONE;
                            result_next.result_sem = 4'(idx_reg);
                        end
                        else if (last_idx)
                        begin
                            done_next          = 1'b1;
                            result_next.status = ST_NONE_FREE;
                        end
                        else
                        begin
                            idx_next = idx_reg + SW'(1);
                        end
                    end
                    CMD_WAIT:
                    begin
                        done_next = 1'b1;
                        if (rec_cur.passes != '0)
                        begin
                            rec_we           = 1'b1;
                            rec_wdata.passes = rec_cur.passes - PW'(1);
                        end
                        else if (queue_full)
                        begin
                            result_next.status = ST_QUEUE_FULL;
                        end
                        else
                        begin
                            wq_we              = 1'b1;
                            rec_we             = 1'b1;
                            rec_wdata.fill     = rec_cur.fill + FW'(1);
                            result_next.status = ST_BLOCKED;
                        end
                    end
                    CMD_POST:
                    begin
                        if (rec_cur.fill != '0)
                        begin
                            // The waiter's pid arrives from the queue memory next cycle.
                            rec_we         = 1'b1;
                            rec_wdata.head = head_inc;
                            rec_wdata.fill = rec_cur.fill - FW'(1);
                        end
                        else if (pass_at_max)
                        begin
                            done_next          = 1'b1;
                            result_next.status = ST_SATURATED;
                        end
                        else
                        begin
                            done_next        = 1'b1;
                            rec_we           = 1'b1;
                            rec_wdata.passes = rec_cur.passes + PW'(1);
                        end
                    end
                    default:
                    begin
                        done_next = 1'b1;
                    end
                endcase
            end
            S_WAKE:
            begin
                done_next   = 1'b1;
                result_next = '{status: ST_WOKEN, result_sem: 4'd0, woken_pid: wq_rdata};
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase

        if (rec_we)
        begin
            rec_valid_next[idx_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rec_valid_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rec_valid_reg <= rec_valid_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        idx_reg    <= idx_next;
        result_reg <= result_next;
    end

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

    // A result beat always lands as the sequencer returns to idle.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result beat while the sequencer is busy");

    // Every accepted command either starts the sequence or answers at once.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> (busy || done))
        else $error("accepted command neither started nor answered");

    // A queue never records more waiters than it can hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        rec_we |-> (32'(rec_wdata.fill) <= QUEUE_DEPTH))
        else $error("queue fill written beyond the queue depth");

    // A woken result only follows the queue read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == ST_WOKEN)) |-> $past(state_reg == S_WAKE))
        else $error("woken result without a queue read");

endmodule
